### sv/pidc_pkg.sv
package pidc_pkg;

    // Field widths
    localparam int unsigned ErrW   = 16;
    localparam int unsigned StepW  = 16;
    localparam int unsigned GainW  = 16;
    localparam int unsigned LimW   = 31;
    localparam int unsigned ShW    = 4;
    localparam int unsigned DataW  = 32;
    localparam int unsigned AddrW  = 5;
    localparam int unsigned PcW    = 4;

    // Fixed scale factors, as shift amounts
    localparam logic [ShW-1:0] IPreShift  = 4'd11;   // divide by 2048
    localparam logic [ShW-1:0] IOutShift  = 4'd13;   // divide by 8192
    localparam logic [ShW-1:0] DPreShift  = 4'd6;    // divide by 64
    localparam logic [ShW-1:0] DOutShift  = 4'd2;    // divide by 4

    // Rate divider: numerator and number of quotient bits
    localparam logic [15:0] DNumerator = 16'hFFFF;
    localparam logic [4:0]  DivSteps   = 5'd16;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_INTEG_LIMIT = 3'd3,
        REG_PROP_SHIFT  = 3'd4,
        REG_USE_DERIV   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [GainW-1:0] prop_gain;
        logic [GainW-1:0] integ_gain;
        logic [GainW-1:0] deriv_gain;
        logic [LimW-1:0]  integ_limit;
        logic [ShW-1:0]   prop_shift;
        logic             use_deriv;
    } t_cfg;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP         = 4'd0,
        OP_LOAD        = 4'd1,
        OP_MUL_P       = 4'd2,
        OP_SET_P       = 4'd3,
        OP_MUL_EDT     = 4'd4,
        OP_MUL_I       = 4'd5,
        OP_INTEG_ADD   = 4'd6,
        OP_INTEG_CLAMP = 4'd7,
        OP_ADD_I       = 4'd8,
        OP_DIV_INIT    = 4'd9,
        OP_DIV_STEP    = 4'd10,
        OP_MUL_D1      = 4'd11,
        OP_MUL_D2      = 4'd12,
        OP_ADD_D       = 4'd13,
        OP_OUT         = 4'd14
    } t_op;

    // Conditions that keep the step counter on the current step
    typedef enum logic [1:0] {
        W_NONE = 2'd0,
        W_IN   = 2'd1,
        W_DIV  = 2'd2,
        W_OUT  = 2'd3
    } t_hold;

    // Conditions for a jump to the step's target
    typedef enum logic [1:0] {
        J_NONE   = 2'd0,
        J_ALWAYS = 2'd1,
        J_NO_I   = 2'd2,
        J_NO_D   = 2'd3
    } t_jump;

    typedef struct packed {
        t_op            op;
        t_hold          hold;
        t_jump          jmp;
        logic [PcW-1:0] target;
    } t_uword;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic i_en;
        logic d_en;
        logic div_busy;
        logic out_full;
    } t_status;

    // Program step addresses used as jump targets
    localparam logic [PcW-1:0] PcLoad   = 4'd0;
    localparam logic [PcW-1:0] PcDCheck = 4'd8;
    localparam logic [PcW-1:0] PcDiv    = 4'd10;
    localparam logic [PcW-1:0] PcOut    = 4'd14;

    // Signed division by 2^k, truncating toward zero.
    function automatic logic [DataW-1:0] f_div_pow2(input logic [DataW-1:0] x,
                                                    input logic [ShW-1:0] k);
        logic [DataW-1:0] bias;
        logic [DataW-1:0] s;
        bias = x[DataW-1] ? ((DataW'(1) << k) - DataW'(1)) : '0;
        s    = x + bias;
        return DataW'($signed(s) >>> k);
    endfunction

    // Control store: one word per program step.
    function automatic t_uword f_ucode(input logic [PcW-1:0] pc);
        t_uword uw;
        uw = '{op: OP_NOP, hold: W_NONE, jmp: J_ALWAYS, target: PcLoad};
        case (pc)
            4'd0:  uw = '{op: OP_LOAD,        hold: W_IN,   jmp: J_NONE, target: PcLoad};
            4'd1:  uw = '{op: OP_MUL_P,       hold: W_NONE, jmp: J_NONE, target: PcLoad};
            4'd2:  uw = '{op: OP_SET_P,       hold: W_NONE, jmp: J_NO_I, target: PcDCheck};
            4'd3:  uw = '{op: OP_MUL_EDT,     hold: W_NONE, jmp: J_NONE, target: PcLoad};
            4'd4:  uw = '{op: OP_MUL_I,       hold: W_NONE, jmp: J_NONE, target: PcLoad};
            4'd5:  uw = '{op: OP_INTEG_ADD,   hold: W_NONE, jmp: J_NONE, target: PcLoad};
            4'd6:  uw = '{op: OP_INTEG_CLAMP, hold: W_NONE, jmp: J_NONE, target: PcLoad};
            4'd7:  uw = '{op: OP_ADD_I,       hold: W_NONE, jmp: J_NONE, target: PcLoad};
            4'd8:  uw = '{op: OP_NOP,         hold: W_NONE, jmp: J_NO_D, target: PcOut};
            4'd9:  uw = '{op: OP_DIV_INIT,    hold: W_NONE, jmp: J_NONE, target: PcLoad};
            4'd10: uw = '{op: OP_DIV_STEP,    hold: W_DIV,  jmp: J_NONE, target: PcDiv};
            4'd11: uw = '{op: OP_MUL_D1,      hold: W_NONE, jmp: J_NONE, target: PcLoad};
            4'd12: uw = '{op: OP_MUL_D2,      hold: W_NONE, jmp: J_NONE, target: PcLoad};
            4'd13: uw = '{op: OP_ADD_D,       hold: W_NONE, jmp: J_NONE, target: PcLoad};
            4'd14: uw = '{op: OP_OUT,         hold: W_OUT,  jmp: J_ALWAYS, target: PcLoad};
            default: uw = '{op: OP_NOP,       hold: W_NONE, jmp: J_ALWAYS, target: PcLoad};
        endcase
        return uw;
    endfunction

endpackage

### sv/pidc_cfg.sv
module pidc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pidc_pkg::AddrW-1:0]   paddr,
    input  logic [pidc_pkg::DataW-1:0]   pwdata,
    output logic [pidc_pkg::DataW-1:0]   prdata,
    output logic                         pready,
    output pidc_pkg::t_cfg               o_cfg
);

    pidc_pkg::t_cfg     r_cfg;
    pidc_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_idx  = pidc_pkg::t_reg_idx'(paddr[pidc_pkg::AddrW-1:2]);
    assign w_wr   = psel && penable && pwrite;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain   <= '0;
            r_cfg.integ_gain  <= '0;
            r_cfg.deriv_gain  <= '0;
            r_cfg.integ_limit <= '0;
            r_cfg.prop_shift  <= '0;
            r_cfg.use_deriv   <= 1'b1;
        end else if (w_wr) begin
            case (w_idx)
                pidc_pkg::REG_PROP_GAIN:   r_cfg.prop_gain   <= pwdata[pidc_pkg::GainW-1:0];
                pidc_pkg::REG_INTEG_GAIN:  r_cfg.integ_gain  <= pwdata[pidc_pkg::GainW-1:0];
                pidc_pkg::REG_DERIV_GAIN:  r_cfg.deriv_gain  <= pwdata[pidc_pkg::GainW-1:0];
                pidc_pkg::REG_INTEG_LIMIT: r_cfg.integ_limit <= pwdata[pidc_pkg::LimW-1:0];
                pidc_pkg::REG_PROP_SHIFT:  r_cfg.prop_shift  <= pwdata[pidc_pkg::ShW-1:0];
                pidc_pkg::REG_USE_DERIV:   r_cfg.use_deriv   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        prdata = '0;
        case (w_idx)
            pidc_pkg::REG_PROP_GAIN:   prdata = 32'(r_cfg.prop_gain);
            pidc_pkg::REG_INTEG_GAIN:  prdata = 32'(r_cfg.integ_gain);
            pidc_pkg::REG_DERIV_GAIN:  prdata = 32'(r_cfg.deriv_gain);
            pidc_pkg::REG_INTEG_LIMIT: prdata = 32'(r_cfg.integ_limit);
            pidc_pkg::REG_PROP_SHIFT:  prdata = 32'(r_cfg.prop_shift);
            pidc_pkg::REG_USE_DERIV:   prdata = 32'(r_cfg.use_deriv);
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### sv/pidc_seq.sv
module pidc_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  pidc_pkg::t_status   i_status,
    output pidc_pkg::t_uword    o_uword
);

    logic [pidc_pkg::PcW-1:0] r_pc;
    logic [pidc_pkg::PcW-1:0] n_pc;
    pidc_pkg::t_uword         w_uw;
    logic                     w_hold;
    logic                     w_jump;

    // Fetch the control word of the current step.
    assign w_uw = pidc_pkg::f_ucode(r_pc);

    // Evaluate hold and jump conditions.
    always_comb begin
        case (w_uw.hold)
            pidc_pkg::W_NONE: w_hold = 1'b0;
            pidc_pkg::W_IN:   w_hold = !i_valid;
            pidc_pkg::W_DIV:  w_hold = i_status.div_busy;
            pidc_pkg::W_OUT:  w_hold = i_status.out_full;
            default:          w_hold = 1'b0;
        endcase
        case (w_uw.jmp)
            pidc_pkg::J_NONE:   w_jump = 1'b0;
            pidc_pkg::J_ALWAYS: w_jump = 1'b1;
            pidc_pkg::J_NO_I:   w_jump = !i_status.i_en;
            pidc_pkg::J_NO_D:   w_jump = !i_status.d_en;
            default:            w_jump = 1'b0;
        endcase
        if (w_hold) begin
            n_pc = r_pc;
        end else if (w_jump) begin
            n_pc = w_uw.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= pidc_pkg::PcLoad;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = w_uw;

endmodule

### sv/pidc_dp.sv
module pidc_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pidc_pkg::t_cfg              i_cfg,
    input  pidc_pkg::t_uword            i_uword,
    input  logic                        i_valid,
    input  logic signed [pidc_pkg::ErrW-1:0]  i_err_sample,
    input  logic [pidc_pkg::StepW-1:0]  i_time_step,
    input  logic                        i_stall,
    output pidc_pkg::t_status           o_status,
    output logic                        o_valid,
    output logic signed [pidc_pkg::DataW-1:0] o_drive_out
);

    localparam int unsigned DW = pidc_pkg::DataW;

    logic [pidc_pkg::ErrW-1:0]  r_err;
    logic [pidc_pkg::StepW-1:0] r_dt;
    logic [DW-1:0]              r_prod;
    logic [DW-1:0]              r_sum;
    logic [DW-1:0]              r_integ;
    logic [pidc_pkg::ErrW-1:0]  r_prev;
    logic [pidc_pkg::ErrW:0]    r_diff;
    logic [11:0]                r_rem;
    logic [15:0]                r_quo;
    logic [4:0]                 r_cnt;
    logic                       r_out_valid;
    logic [DW-1:0]              r_out;

    logic [DW-1:0]  w_err32;
    logic [DW-1:0]  w_mul_a;
    logic [DW-1:0]  w_mul_b;
    logic [DW-1:0]  w_mul;
    logic [DW-1:0]  w_hi;
    logic [DW-1:0]  w_lo;
    logic [DW-1:0]  w_clamped;
    logic [11:0]    w_dvs;
    logic [12:0]    w_shift;
    logic [13:0]    w_trial;
    logic           w_fits;
    logic           w_out_full;
    pidc_pkg::t_op  w_op;

    assign w_op    = i_uword.op;
    assign w_err32 = {{(DW - pidc_pkg::ErrW){r_err[pidc_pkg::ErrW-1]}}, r_err};

    // Shared multiplier, low 32 bits of the product.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (w_op)
            pidc_pkg::OP_MUL_P: begin
                w_mul_a = w_err32;
                w_mul_b = DW'(i_cfg.prop_gain);
            end
            pidc_pkg::OP_MUL_EDT: begin
                w_mul_a = w_err32;
                w_mul_b = DW'(r_dt);
            end
            pidc_pkg::OP_MUL_I: begin
                w_mul_a = pidc_pkg::f_div_pow2(r_prod, pidc_pkg::IPreShift);
                w_mul_b = DW'(i_cfg.integ_gain);
            end
            pidc_pkg::OP_MUL_D1: begin
                w_mul_a = {{(DW - pidc_pkg::ErrW - 1){r_diff[pidc_pkg::ErrW]}}, r_diff};
                w_mul_b = DW'(r_quo);
            end
            pidc_pkg::OP_MUL_D2: begin
                w_mul_a = pidc_pkg::f_div_pow2(r_prod, pidc_pkg::DPreShift);
                w_mul_b = DW'(i_cfg.deriv_gain);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        w_mul = w_mul_a * w_mul_b;
    end

    // Symmetric integrator clamp.
    always_comb begin
        w_hi = DW'(i_cfg.integ_limit);
        w_lo = DW'(0) - w_hi;
        if ($signed(r_integ) < $signed(w_lo)) begin
            w_clamped = w_lo;
        end else if ($signed(w_hi) < $signed(r_integ)) begin
            w_clamped = w_hi;
        end else begin
            w_clamped = r_integ;
        end
    end

    // One restoring division step for the derivative rate.
    assign w_dvs   = r_dt[pidc_pkg::StepW-1:4];
    assign w_shift = {r_rem, r_quo[15]};
    assign w_trial = {1'b0, w_shift} - {2'b00, w_dvs};
    assign w_fits  = !w_trial[13];

    assign w_out_full = r_out_valid && i_stall;

    // Control state: integrator, last error, divider count, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ     <= '0;
            r_prev      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (w_op)
                pidc_pkg::OP_INTEG_ADD:   r_integ <= r_integ + r_prod;
                pidc_pkg::OP_INTEG_CLAMP: r_integ <= w_clamped;
                default: ;
            endcase
            if (w_op == pidc_pkg::OP_DIV_INIT) begin
                r_prev <= r_err;
                r_cnt  <= pidc_pkg::DivSteps;
            end else if (w_op == pidc_pkg::OP_DIV_STEP && r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (w_op == pidc_pkg::OP_OUT && !w_out_full) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (w_op)
            pidc_pkg::OP_LOAD: begin
                if (i_valid) begin
                    r_err <= i_err_sample;
                    r_dt  <= i_time_step;
                end
            end
            pidc_pkg::OP_MUL_P, pidc_pkg::OP_MUL_EDT, pidc_pkg::OP_MUL_I,
            pidc_pkg::OP_MUL_D1, pidc_pkg::OP_MUL_D2: begin
                r_prod <= w_mul;
            end
            pidc_pkg::OP_SET_P: begin
                r_sum <= pidc_pkg::f_div_pow2(r_prod, i_cfg.prop_shift);
            end
            pidc_pkg::OP_ADD_I: begin
                r_sum <= r_sum + pidc_pkg::f_div_pow2(r_integ, pidc_pkg::IOutShift);
            end
            pidc_pkg::OP_ADD_D: begin
                r_sum <= r_sum + pidc_pkg::f_div_pow2(r_prod, pidc_pkg::DOutShift);
            end
            pidc_pkg::OP_DIV_INIT: begin
                r_diff <= {r_err[pidc_pkg::ErrW-1], r_err} - {r_prev[pidc_pkg::ErrW-1], r_prev};
                r_rem  <= '0;
                r_quo  <= pidc_pkg::DNumerator;
            end
            pidc_pkg::OP_DIV_STEP: begin
                if (r_cnt != '0) begin
                    r_rem <= w_fits ? w_trial[11:0] : w_shift[11:0];
                    r_quo <= {r_quo[14:0], w_fits};
                end
            end
            pidc_pkg::OP_OUT: begin
                if (!w_out_full) begin
                    r_out <= r_sum;
                end
            end
            default: ;
        endcase
    end

    assign o_status.i_en     = (i_cfg.integ_gain != '0) && (r_dt != '0);
    assign o_status.d_en     = i_cfg.use_deriv && (i_cfg.deriv_gain != '0) && (w_dvs != '0);
    assign o_status.div_busy = (r_cnt != '0);
    assign o_status.out_full = w_out_full;

    assign o_valid     = r_out_valid;
    assign o_drive_out = r_out;

endmodule

### sv/pid_controller_step.sv
// PID controller step with a clamped integer integrator.
// Input channel: i_valid / o_stall carry one transaction of i_err_sample and
// i_time_step. Output channel: o_valid / i_stall carry one transaction of
// o_drive_out. A transaction completes at a clock edge where valid is high
// and stall is low.
// A small microcoded sequencer walks each sample through one shared 32x32
// multiplier, a shift-and-round unit and a one-bit-per-cycle divider for the
// derivative rate. The program skips the integral and derivative steps
// when those terms are off. A new sample is taken in the cycle after the
// result is written, so each sample is finished before the next is taken.
// The output register frees the sequencer: a new sample is accepted while
// a result still waits, and the sequencer holds at its last step only if
// that result is still stalled when the next one is ready.
// Synchronous active-low reset clears the integrator and the last error,
// restores the register defaults (PID mode on, all gains zero) and empties
// the output register. Registers are written through the APB port, and the
// user must write them only while the block is idle; nothing enforces it.
module pid_controller_step (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pidc_pkg::AddrW-1:0]          paddr,
    input  logic [pidc_pkg::DataW-1:0]          pwdata,
    output logic [pidc_pkg::DataW-1:0]          prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [pidc_pkg::ErrW-1:0]    i_err_sample,
    input  logic [pidc_pkg::StepW-1:0]          i_time_step,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [pidc_pkg::DataW-1:0]   o_drive_out
);

    pidc_pkg::t_cfg    w_cfg;
    pidc_pkg::t_uword  w_uword;
    pidc_pkg::t_status w_status;

    pidc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pidc_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (w_status),
        .o_uword  (w_uword)
    );

    pidc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_uword      (w_uword),
        .i_valid      (i_valid),
        .i_err_sample (i_err_sample),
        .i_time_step  (i_time_step),
        .i_stall      (i_stall),
        .o_status     (w_status),
        .o_valid      (o_valid),
        .o_drive_out  (o_drive_out)
    );

    // Input is taken only at the load step of the program.
    assign o_stall = (w_uword.op != pidc_pkg::OP_LOAD);

endmodule

### tb/tb_pid_controller_step.sv
module tb_pid_controller_step;

    localparam int unsigned ClkHalf      = 6;
    localparam int unsigned ResetCycles  = 4;
    localparam int unsigned DrainCycles  = 48;
    localparam int unsigned StuckLimit   = 4000;
    localparam int unsigned RandomPhases = 24;

    // Field widths of the block.
    localparam int unsigned ErrW  = pidc_pkg::ErrW;
    localparam int unsigned StepW = pidc_pkg::StepW;
    localparam int unsigned GainW = pidc_pkg::GainW;
    localparam int unsigned LimW  = pidc_pkg::LimW;
    localparam int unsigned ShW   = pidc_pkg::ShW;
    localparam int unsigned DataW = pidc_pkg::DataW;
    localparam int unsigned AddrW = pidc_pkg::AddrW;

    // Addresses past the end of the register map; writes there must be ignored.
    localparam logic [2:0] RegUnmappedLo = 3'd6;
    localparam logic [2:0] RegUnmappedHi = 3'd7;

    // Fixed scale factors of the control law.
    localparam logic [DataW-1:0] IntegPrescale = 32'd2048;
    localparam logic [DataW-1:0] IntegOutScale = 32'd8192;
    localparam logic [DataW-1:0] RateNumerator = 32'h0000_FFFF;
    localparam logic [DataW-1:0] MinRateStep   = 32'd16;
    localparam logic [DataW-1:0] RatePrescale  = 32'd64;
    localparam logic [DataW-1:0] DerivOutScale = 32'd4;

    // Predicts the drive value of every accepted sample and checks the results.
    class t_drive_scoreboard;
        bit [GainW-1:0]   kp;
        bit [GainW-1:0]   ki;
        bit [GainW-1:0]   kd;
        bit [LimW-1:0]    imax;
        bit [ShW-1:0]     p_shift;
        bit               use_d;
        bit [DataW-1:0]   integ_acc;
        bit [ErrW-1:0]    last_err;
        bit [DataW-1:0]   expected_drive_q[$];
        int unsigned      mismatches;

        function new();
            kp         = '0;
            ki         = '0;
            kd         = '0;
            imax       = '0;
            p_shift    = '0;
            use_d      = 1'b1;
            integ_acc  = '0;
            last_err   = '0;
            mismatches = 0;
        endfunction

        // Two's complement value divided by a positive divisor, rounded toward zero.
        function bit [DataW-1:0] div_toward_zero(bit [DataW-1:0] x, bit [DataW-1:0] d);
            if (x[DataW-1]) begin
                return -((-x) / d);
            end
            return x / d;
        endfunction

        function void write_reg(logic [2:0] idx, logic [DataW-1:0] val);
            case (idx)
                pidc_pkg::REG_PROP_GAIN:   kp      = val[GainW-1:0];
                pidc_pkg::REG_INTEG_GAIN:  ki      = val[GainW-1:0];
                pidc_pkg::REG_DERIV_GAIN:  kd      = val[GainW-1:0];
                pidc_pkg::REG_INTEG_LIMIT: imax    = val[LimW-1:0];
                pidc_pkg::REG_PROP_SHIFT:  p_shift = val[ShW-1:0];
                pidc_pkg::REG_USE_DERIV:   use_d   = val[0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [ErrW-1:0] err, logic [StepW-1:0] dt);
            bit [DataW-1:0] e;
            bit [DataW-1:0] dtv;
            bit [DataW-1:0] p_term;
            bit [DataW-1:0] i_term;
            bit [DataW-1:0] d_term;
            bit [DataW-1:0] hi;
            bit [DataW-1:0] lo;
            bit [DataW-1:0] inc;
            bit [DataW-1:0] diff;
            bit [DataW-1:0] rate;
            e      = DataW'($signed(err));
            dtv    = DataW'(dt);
            p_term = div_toward_zero(e * DataW'(kp), DataW'(1) << p_shift);
            i_term = '0;
            d_term = '0;

            // The integrator moves only with a nonzero gain and a nonzero step.
            if (ki != 0 && dt != 0) begin
                hi        = DataW'(imax);
                lo        = -hi;
                inc       = div_toward_zero(e * dtv, IntegPrescale) * DataW'(ki);
                integ_acc = integ_acc + inc;
                if ($signed(integ_acc) < $signed(lo)) begin
                    integ_acc = lo;
                end else if ($signed(hi) < $signed(integ_acc)) begin
                    integ_acc = hi;
                end
                i_term = div_toward_zero(integ_acc, IntegOutScale);
            end

            // Derivative term needs PID mode, a gain and a step of at least 16 units.
            if (use_d && kd != 0 && dtv >= MinRateStep) begin
                diff     = e - DataW'($signed(last_err));
                rate     = RateNumerator / (dtv / MinRateStep);
                last_err = err;
                diff     = div_toward_zero(diff * rate, RatePrescale);
                d_term   = div_toward_zero(diff * DataW'(kd), DerivOutScale);
            end

            expected_drive_q.push_back(p_term + i_term + d_term);
        endfunction

        function void check_drive(logic [DataW-1:0] got);
            bit [DataW-1:0] want;
            if (expected_drive_q.size() == 0) begin
                $error("drive_out: unexpected result, expected none, actual %0d",
                       $signed(got));
                mismatches++;
                return;
            end
            want = expected_drive_q.pop_front();
            if (got !== want) begin
                $error("drive_out: expected %0d, actual %0d", $signed(want), $signed(got));
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_drive_q.size();
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n      = 1'b0;
    logic                     psel         = 1'b0;
    logic                     penable      = 1'b0;
    logic                     pwrite       = 1'b0;
    logic [AddrW-1:0]         paddr        = '0;
    logic [DataW-1:0]         pwdata       = '0;
    logic [DataW-1:0]         prdata;
    logic                     pready;
    logic                     i_valid      = 1'b0;
    logic                     o_stall;
    logic signed [ErrW-1:0]   i_err_sample = '0;
    logic [StepW-1:0]         i_time_step  = '0;
    logic                     o_valid;
    logic                     i_stall      = 1'b0;
    logic signed [DataW-1:0]  o_drive_out;

    int unsigned send_idle_pct = 13;
    int unsigned recv_idle_pct = 85;

    t_drive_scoreboard sb = new();

    pid_controller_step dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_err_sample (i_err_sample),
        .i_time_step  (i_time_step),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_drive_out  (o_drive_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #ClkHalf i_clk = ~i_clk;
    end

    // Result side: check every output transaction and stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_drive(o_drive_out);
        end
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Watchdog: the run ends when nothing has moved for too long.
    initial begin
        int unsigned stuck;
        stuck = 0;
        while (stuck < StuckLimit) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || psel) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    // One register write: setup cycle, access cycle until pready, then idle.
    task automatic apb_write(input logic [2:0] idx, input logic [DataW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Waits until every expected result is out and the sequencer has gone quiet.
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [DataW-1:0] kp, input logic [DataW-1:0] ki,
                                  input logic [DataW-1:0] kd, input logic [DataW-1:0] imax,
                                  input logic [DataW-1:0] sh, input logic [DataW-1:0] ud);
        settle();
        apb_write(pidc_pkg::REG_PROP_GAIN, kp);
        apb_write(pidc_pkg::REG_INTEG_GAIN, ki);
        apb_write(pidc_pkg::REG_DERIV_GAIN, kd);
        apb_write(pidc_pkg::REG_INTEG_LIMIT, imax);
        apb_write(pidc_pkg::REG_PROP_SHIFT, sh);
        apb_write(pidc_pkg::REG_USE_DERIV, ud);
    endtask

    // One input transaction, preceded by random idle cycles.
    task automatic send_sample(input logic [ErrW-1:0] err, input logic [StepW-1:0] dt);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid      <= 1'b0;
            i_err_sample <= $urandom();
            i_time_step  <= $urandom();
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_err_sample <= err;
        i_time_step  <= dt;
        do @(posedge i_clk); while (o_stall);
        sb.note_sample(err, dt);
    endtask

    function automatic logic [ErrW-1:0] rand_err();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return ErrW'($urandom_range(64) - 32);
            default: return ErrW'($urandom());
        endcase
    endfunction

    function automatic logic [StepW-1:0] rand_step();
        case ($urandom_range(7))
            0:       return '0;
            1:       return StepW'($urandom_range(15, 1));
            2:       return StepW'(16);
            3:       return '1;
            4:       return StepW'($urandom_range(1024, 16));
            default: return StepW'($urandom());
        endcase
    endfunction

    // Register value of the given width: zero, all ones or random.
    function automatic logic [DataW-1:0] rand_setting(input int unsigned w);
        logic [DataW-1:0] mask;
        logic [DataW-1:0] v;
        mask = (DataW'(1) << w) - DataW'(1);
        case ($urandom_range(3))
            0:       v = '0;
            1:       v = mask;
            default: v = $urandom() & mask;
        endcase
        // Bits above the register width must be dropped by the block.
        if ($urandom_range(1) == 1) begin
            v = v | ($urandom() & ~mask);
        end
        return v;
    endfunction

    initial begin
        logic [DataW-1:0] imax;
        int unsigned      n;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register defaults straight out of reset: all gains are zero.
        send_sample(16'h7FFF, 16'd100);
        send_sample(16'h8000, 16'd0);
        send_sample(16'h0000, 16'd16);

        // Every gain at its maximum with the widest clamp.
        apply_settings(32'hFFFF, 32'hFFFF, 32'hFFFF, 32'h7FFF_FFFF, 32'd0, 32'd1);
        send_sample(16'h7FFF, 16'hFFFF);
        send_sample(16'h8000, 16'hFFFF);
        send_sample(16'h8000, 16'd16);
        send_sample(16'h7FFF, 16'd15);
        send_sample(16'h0001, 16'd0);
        send_sample(16'hFFFF, 16'd17);
        send_sample(16'h0000, 16'd31);
        send_sample(16'h7FFF, 16'd32);
        send_sample(16'h8000, 16'd1);

        // PI mode with a tight clamp; the last error must stay frozen.
        apply_settings(32'd1, 32'd300, 32'd40000, 32'd5000, 32'd15, 32'd0);
        apb_write(RegUnmappedLo, 32'hFFFF_FFFF);
        apb_write(RegUnmappedHi, $urandom());
        send_sample(16'hFFFF, 16'd100);
        send_sample(16'h0001, 16'd100);
        send_sample(16'h7FFF, 16'd4000);
        send_sample(16'h8000, 16'd4000);
        send_sample(16'h8000, 16'd4000);
        send_sample(16'd500, 16'd20);
        send_sample(16'h0000, 16'd0);

        // Back to PID mode with the smallest derivative gain.
        apply_settings(32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd1);
        send_sample(16'd100, 16'd16);
        send_sample(-16'sd100, 16'hFFFF);
        send_sample(16'h7FFF, 16'd16);
        send_sample(16'h8000, 16'd16);

        // Random settings, each followed by a batch of random samples.
        for (int phase = 0; phase < RandomPhases; phase++) begin
            if (phase == RandomPhases / 3) begin
                send_idle_pct = 85;
                recv_idle_pct = 13;
            end else if (phase == 2 * RandomPhases / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if ($urandom_range(2) == 0) begin
                imax = $urandom_range(1 << 20, 0);
            end else begin
                imax = rand_setting(LimW);
            end
            apply_settings(rand_setting(GainW), rand_setting(GainW), rand_setting(GainW),
                           imax, rand_setting(ShW), rand_setting(1));
            if (phase % 4 == 0) begin
                apb_write(RegUnmappedLo, $urandom());
                apb_write(RegUnmappedHi, $urandom());
            end
            n = $urandom_range(90, 60);
            repeat (n) send_sample(rand_err(), rand_step());
        end

        settle();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### pid_controller_step.f
sv/pidc_pkg.sv
sv/pidc_cfg.sv
sv/pidc_seq.sv
sv/pidc_dp.sv
sv/pid_controller_step.sv
tb/tb_pid_controller_step.sv
